// ===== hw/rtl/rbid_pkg.sv =====
// Shared types, constants and the microcode table for the reverse
// bitstream instruction decoder.
// No dependencies; every other rbid file imports this package.
package rbid_pkg;

  // Record kinds as they appear on out_tuser
  localparam logic [1:0] K_INSTR = 2'd0;
  localparam logic [1:0] K_LABEL = 2'd1;
  localparam logic [1:0] K_END   = 2'd2;
  localparam logic [1:0] K_TRUNC = 2'd3;

  localparam int unsigned BUF_W  = 16;
  localparam int unsigned HELD_W = 5;
  localparam int unsigned NEED_W = 4;

  // Handshake-level control state
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_RUN,
    CS_DONE
  } ctl_st_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_COUNT,
    S_OPCODE,
    S_ATYPE,
    S_AVALUE,
    S_BTYPE,
    S_BVALUE,
    S_LABEL,
    S_INSTR,
    S_PADEND
  } step_t;

  // Field width taken by a step
  typedef enum logic [2:0] {
    W_NONE,
    W_TWO,
    W_THREE,
    W_FIVE,
    W_AVAL,
    W_BVAL
  } wsel_t;

  // Datapath action of a step
  typedef enum logic [3:0] {
    A_LOAD_COUNT,
    A_LOAD_OP,
    A_LOAD_AT,
    A_LOAD_AV,
    A_LOAD_BT,
    A_LOAD_BV,
    A_EMIT_INSTR,
    A_EMIT_LABEL,
    A_EMIT_END
  } act_t;

  // Jump condition: next_t when it holds, next_f otherwise
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_V_ZERO,
    C_NO_OPND,
    C_ONE_OPND,
    C_LEFT_ONE,
    C_END_OK
  } cond_t;

  typedef struct packed {
    wsel_t wsel;
    act_t  act;
    cond_t cond;
    step_t next_t;
    step_t next_f;
  } ucode_t;

  // Bit buffer control from the sequencer
  typedef struct packed {
    logic              load;
    logic              consume;
    logic [NEED_W-1:0] need;
  } bb_ctrl_t;

  // Bit buffer status to the sequencer
  typedef struct packed {
    logic [7:0]        field;
    logic [HELD_W-1:0] held;
    logic              enough;
  } bb_stat_t;

  // One result record
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] opcode;
    logic [1:0] a_type;
    logic [7:0] a_value;
    logic [1:0] b_type;
    logic [7:0] b_value;
    logic [2:0] label;
    logic [3:0] pad;
    logic       eop;
  } rec_t;

  // Value width for an operand type
  function automatic logic [NEED_W-1:0] value_bits(input logic [1:0] typ);
    logic [NEED_W-1:0] w;
    unique case (typ)
      2'd0:    w = 4'd8;
      2'd1:    w = 4'd3;
      default: w = 4'd5;
    endcase
    return w;
  endfunction

  // Microcode table
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t u;
    unique case (s)
      S_COUNT:  u = '{W_FIVE,  A_LOAD_COUNT, C_V_ZERO,   S_LABEL,  S_OPCODE};
      S_OPCODE: u = '{W_THREE, A_LOAD_OP,    C_NO_OPND,  S_INSTR,  S_ATYPE};
      S_ATYPE:  u = '{W_TWO,   A_LOAD_AT,    C_ALWAYS,   S_AVALUE, S_AVALUE};
      S_AVALUE: u = '{W_AVAL,  A_LOAD_AV,    C_ONE_OPND, S_INSTR,  S_BTYPE};
      S_BTYPE:  u = '{W_TWO,   A_LOAD_BT,    C_ALWAYS,   S_BVALUE, S_BVALUE};
      S_BVALUE: u = '{W_BVAL,  A_LOAD_BV,    C_ALWAYS,   S_INSTR,  S_INSTR};
      S_LABEL:  u = '{W_THREE, A_EMIT_LABEL, C_END_OK,   S_PADEND, S_COUNT};
      S_INSTR:  u = '{W_NONE,  A_EMIT_INSTR, C_LEFT_ONE, S_LABEL,  S_OPCODE};
      S_PADEND: u = '{W_NONE,  A_EMIT_END,   C_ALWAYS,   S_PADEND, S_PADEND};
      default:  u = '{W_FIVE,  A_LOAD_COUNT, C_V_ZERO,   S_LABEL,  S_OPCODE};
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/rbid_bitbuf.sv =====
// Bit buffer: appends input bytes above the held bits and hands out
// LSB-first fields of up to eight bits. Depends on rbid_pkg.
module rbid_bitbuf
  import rbid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  bb_ctrl_t bb_ctrl,
  input  logic [7:0] data_byte,
  output bb_stat_t bb_stat
);

  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [7:0]        mask;
  logic [BUF_W-1:0]  byte_shifted;

  // Extract the low field and report whether it is complete
  assign mask         = 8'((9'd1 << bb_ctrl.need) - 9'd1);
  assign byte_shifted = {8'd0, data_byte} << held_r[3:0];

  assign bb_stat.field  = buf_r[7:0] & mask;
  assign bb_stat.held   = held_r;
  assign bb_stat.enough = held_r >= {1'b0, bb_ctrl.need};

  // Append on a transfer, drop consumed bits
  always_comb begin
    buf_nxt  = buf_r;
    held_nxt = held_r;
    if (bb_ctrl.load) begin
      buf_nxt  = buf_r | byte_shifted;
      held_nxt = held_r + 5'd8;
    end else if (bb_ctrl.consume) begin
      buf_nxt  = buf_r >> bb_ctrl.need;
      held_nxt = held_r - {1'b0, bb_ctrl.need};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      held_r <= '0;
    end else begin
      buf_r  <= buf_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

// ===== hw/rtl/rbid_seq.sv =====
// Microcoded sequencer: step counter, microcode lookup, jump conditions,
// held instruction fields and record assembly. Depends on rbid_pkg.
module rbid_seq
  import rbid_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_xfer,
  input  logic     in_first,
  input  logic     slot_free,
  input  bb_stat_t bb_stat,
  output bb_ctrl_t bb_ctrl,
  output logic     in_ready,
  output logic     rec_valid,
  output rec_t     rec
);

  ctl_st_t     state_r, state_nxt;
  step_t       step_r, step_nxt;
  logic        first_r, first_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [1:0]  at_r, at_nxt;
  logic [7:0]  av_r, av_nxt;
  logic [1:0]  bt_r, bt_nxt;
  logic [7:0]  bv_r, bv_nxt;

  ucode_t            uc;
  logic [NEED_W-1:0] need;
  logic [HELD_W-1:0] held_after;
  logic              short_w, emits, cond_hit, step_go, trunc_go;

  assign uc = ucode_rom(step_r);

  // Field width of the current step
  always_comb begin
    unique case (uc.wsel)
      W_NONE:  need = 4'd0;
      W_TWO:   need = 4'd2;
      W_THREE: need = 4'd3;
      W_FIVE:  need = 4'd5;
      W_AVAL:  need = value_bits(at_r);
      W_BVAL:  need = value_bits(bt_r);
      default: need = 4'd0;
    endcase
  end

  assign short_w    = !bb_stat.enough;
  assign held_after = bb_stat.held - {1'b0, need};
  assign emits      = (uc.act == A_EMIT_INSTR) || (uc.act == A_EMIT_LABEL) ||
                      (uc.act == A_EMIT_END);
  assign step_go    = (state_r == CS_RUN) && !short_w && (!emits || slot_free);
  assign trunc_go   = (state_r == CS_RUN) && short_w && first_r && slot_free;

  // Jump condition
  always_comb begin
    unique case (uc.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_V_ZERO:   cond_hit = bb_stat.field == 8'd0;
      C_NO_OPND:  cond_hit = bb_stat.field[2:0] == 3'd2;
      C_ONE_OPND: cond_hit = (op_r == 3'd1) || (op_r == 3'd5) ||
                             (op_r == 3'd6) || (op_r == 3'd7);
      C_LEFT_ONE: cond_hit = left_r == 5'd1;
      C_END_OK:   cond_hit = first_r && (held_after <= 5'd8);
      default:    cond_hit = 1'b0;
    endcase
  end

  // Next control state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_IDLE: begin
        if (in_xfer) state_nxt = CS_RUN;
      end
      CS_RUN: begin
        if (short_w) begin
          if (!first_r) state_nxt = CS_IDLE;
          else if (slot_free) state_nxt = CS_DONE;
        end else if (step_go && (uc.act == A_EMIT_END)) begin
          state_nxt = CS_DONE;
        end
      end
      CS_DONE: state_nxt = CS_DONE;
      default: state_nxt = CS_IDLE;
    endcase
  end

  // Handshake, buffer control and record assembly
  always_comb begin
    in_ready        = (state_r == CS_IDLE) || (state_r == CS_DONE);
    bb_ctrl.load    = in_xfer && (state_r == CS_IDLE);
    bb_ctrl.consume = step_go;
    bb_ctrl.need    = need;
    rec_valid       = (step_go && emits) || trunc_go;
    rec             = '0;
    if (trunc_go) begin
      rec.kind = K_TRUNC;
      rec.eop  = 1'b1;
    end else begin
      unique case (uc.act)
        A_EMIT_INSTR: begin
          rec.kind    = K_INSTR;
          rec.opcode  = op_r;
          rec.a_type  = at_r;
          rec.a_value = av_r;
          rec.b_type  = bt_r;
          rec.b_value = bv_r;
        end
        A_EMIT_LABEL: begin
          rec.kind  = K_LABEL;
          rec.label = bb_stat.field[2:0];
        end
        A_EMIT_END: begin
          rec.kind = K_END;
          rec.pad  = bb_stat.held[3:0];
          rec.eop  = 1'b1;
        end
        default: rec = '0;
      endcase
    end
  end

  // Step counter and held fields
  always_comb begin
    step_nxt  = step_r;
    first_nxt = first_r;
    left_nxt  = left_r;
    op_nxt    = op_r;
    at_nxt    = at_r;
    av_nxt    = av_r;
    bt_nxt    = bt_r;
    bv_nxt    = bv_r;
    if (bb_ctrl.load) first_nxt = in_first;
    if (step_go) begin
      step_nxt = cond_hit ? uc.next_t : uc.next_f;
      unique case (uc.act)
        A_LOAD_COUNT: left_nxt = bb_stat.field[4:0];
        A_LOAD_OP: begin
          op_nxt = bb_stat.field[2:0];
          at_nxt = '0;
          av_nxt = '0;
          bt_nxt = '0;
          bv_nxt = '0;
        end
        A_LOAD_AT:    at_nxt   = bb_stat.field[1:0];
        A_LOAD_AV:    av_nxt   = bb_stat.field;
        A_LOAD_BT:    bt_nxt   = bb_stat.field[1:0];
        A_LOAD_BV:    bv_nxt   = bb_stat.field;
        A_EMIT_INSTR: left_nxt = left_r - 5'd1;
        default:      left_nxt = left_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      step_r  <= S_COUNT;
      first_r <= 1'b0;
      left_r  <= '0;
      op_r    <= '0;
      at_r    <= '0;
      av_r    <= '0;
      bt_r    <= '0;
      bv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      first_r <= first_nxt;
      left_r  <= left_nxt;
      op_r    <= op_nxt;
      at_r    <= at_nxt;
      av_r    <= av_nxt;
      bt_r    <= bt_nxt;
      bv_r    <= bv_nxt;
    end
  end

endmodule

// ===== hw/rtl/reverse_bitstream_instruction_decoder.sv =====
// Reverse bitstream instruction decoder, top level: stream ports, result register.
// Each byte is transferred, then one microcode step runs per completed field or record
// until a step finds the buffer short; only then is the next byte accepted.
// Records appear in the cycle after their step in a one-deep register; a full one stalls.
// Synchronous active-low reset returns to the count field with an empty bit buffer.
// Depends on rbid_pkg, rbid_bitbuf and rbid_seq.
module reverse_bitstream_instruction_decoder
  import rbid_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // first_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] opcode, [4:3] operand_a_type,
                                  // [12:5] operand_a_value, [14:13] operand_b_type,
                                  // [22:15] operand_b_value, [25:23] label number,
                                  // [29:26] padding_bits, [31:30] zero
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast   // end_of_program
);

  bb_ctrl_t bb_ctrl;
  bb_stat_t bb_stat;
  rec_t     rec, out_rec_r, out_rec_nxt;
  logic     rec_valid, in_xfer, slot_free;
  logic     out_valid_r, out_valid_nxt;

  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  rbid_bitbuf u_bitbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .bb_ctrl   (bb_ctrl),
    .data_byte (in_tdata),
    .bb_stat   (bb_stat)
  );

  rbid_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_xfer   (in_xfer),
    .in_first  (in_tlast),
    .slot_free (slot_free),
    .bb_stat   (bb_stat),
    .bb_ctrl   (bb_ctrl),
    .in_ready  (in_tready),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Load a record when the slot frees, drop valid once the transfer completes
  always_comb begin
    out_rec_nxt   = out_rec_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (rec_valid) begin
      out_rec_nxt   = rec;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rec_r <= out_rec_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rec_r.kind;
  assign out_tlast  = out_rec_r.eop;
  assign out_tdata  = {2'b00, out_rec_r.pad, out_rec_r.label, out_rec_r.b_value,
                       out_rec_r.b_type, out_rec_r.a_value, out_rec_r.a_type,
                       out_rec_r.opcode};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for reverse_bitstream_instruction_decoder.
// Feeds one program file last byte first over the input stream and checks every record.
// Depends on rbid_pkg and the decoder top level.
`timescale 1ns / 1ps

module testbench;
  import rbid_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } prog_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // [7:0] data_byte
  logic        in_tlast = 1'b0;   // first_of_file
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [2:0] opcode, [4:3] operand_a_type,
                                  // [12:5] operand_a_value, [14:13] operand_b_type,
                                  // [22:15] operand_b_value, [25:23] label number,
                                  // [29:26] padding_bits, [31:30] zero
  logic [1:0]  out_tuser;         // [1:0] record_kind
  logic        out_tlast;         // end_of_program

  reverse_bitstream_instruction_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectation stores
  bit          prog_bits[$];
  prog_byte_t  program_bytes[$];
  rec_t        expected_records[$];
  int unsigned total_bytes;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;

  // Shadow decoder state
  step_t       dec_phase = S_COUNT;
  logic [15:0] dec_buf = '0;
  int unsigned dec_held = 0;
  logic [4:0]  dec_left = '0;
  logic [2:0]  dec_op = '0;
  logic [1:0]  dec_a_type = '0;
  logic [7:0]  dec_a_value = '0;
  logic [1:0]  dec_b_type = '0;
  bit          dec_finished = 1'b0;
  int unsigned rec_count;

  function automatic int unsigned opnd_width(input logic [1:0] t);
    if (t == 2'd0) return 8;
    if (t == 2'd1) return 3;
    return 5;
  endfunction

  function automatic int unsigned opnd_count(input logic [2:0] op);
    if (op == 3'd2) return 0;
    if (op == 3'd1 || op == 3'd5 || op == 3'd6 || op == 3'd7) return 1;
    return 2;
  endfunction

  function automatic int unsigned field_width();
    case (dec_phase)
      S_COUNT:          return 5;
      S_OPCODE:         return 3;
      S_ATYPE, S_BTYPE: return 2;
      S_AVALUE:         return opnd_width(dec_a_type);
      S_BVALUE:         return opnd_width(dec_b_type);
      default:          return 3;
    endcase
  endfunction

  // At most four records can come out of one byte; drop any beyond that
  function automatic void queue_record(input rec_t r);
    if (rec_count < 4) begin
      expected_records.push_back(r);
      rec_count++;
    end
  endfunction

  function automatic void instruction_done();
    dec_left = dec_left - 5'd1;
    dec_phase = (dec_left != 5'd0) ? S_OPCODE : S_LABEL;
  endfunction

  // Shift one byte into the shadow buffer and decode every field it completes
  task automatic decode_program_byte(input logic [7:0] data, input logic first);
    int unsigned need;
    logic [7:0]  v;
    rec_t        r;
    if (dec_finished) return;
    rec_count = 0;
    dec_buf = dec_buf | (16'(data) << dec_held);
    dec_held += 8;
    while (!dec_finished) begin
      need = field_width();
      if (dec_held < need) break;
      v = 8'(dec_buf & ((16'd1 << need) - 16'd1));
      dec_buf = dec_buf >> need;
      dec_held -= need;
      r = '0;
      case (dec_phase)
        S_COUNT: begin
          dec_left = v[4:0];
          dec_phase = (v == 8'd0) ? S_LABEL : S_OPCODE;
        end
        S_OPCODE: begin
          dec_op = v[2:0];
          dec_a_type = '0;
          dec_a_value = '0;
          dec_b_type = '0;
          if (opnd_count(dec_op) == 0) begin
            r.kind = K_INSTR;
            r.opcode = dec_op;
            queue_record(r);
            instruction_done();
          end else begin
            dec_phase = S_ATYPE;
          end
        end
        S_ATYPE: begin
          dec_a_type = v[1:0];
          dec_phase = S_AVALUE;
        end
        S_AVALUE: begin
          dec_a_value = v;
          if (opnd_count(dec_op) == 1) begin
            r.kind = K_INSTR;
            r.opcode = dec_op;
            r.a_type = dec_a_type;
            r.a_value = v;
            queue_record(r);
            instruction_done();
          end else begin
            dec_phase = S_BTYPE;
          end
        end
        S_BTYPE: begin
          dec_b_type = v[1:0];
          dec_phase = S_BVALUE;
        end
        S_BVALUE: begin
          r.kind = K_INSTR;
          r.opcode = dec_op;
          r.a_type = dec_a_type;
          r.a_value = dec_a_value;
          r.b_type = dec_b_type;
          r.b_value = v;
          queue_record(r);
          instruction_done();
        end
        default: begin
          r.kind = K_LABEL;
          r.label = v[2:0];
          queue_record(r);
          // The program ends once a label completes in the file's first byte with at most eight bits left
          if (first && dec_held <= 8) begin
            r = '0;
            r.kind = K_END;
            r.pad = 4'(dec_held);
            r.eop = 1'b1;
            queue_record(r);
            dec_finished = 1'b1;
          end else begin
            dec_phase = S_COUNT;
          end
        end
      endcase
    end
    // First byte consumed without a clean end: flag truncation
    if (first && !dec_finished) begin
      r = '0;
      r.kind = K_TRUNC;
      r.eop = 1'b1;
      queue_record(r);
      dec_finished = 1'b1;
    end
  endtask

  // Program builders, bits appended in stream order
  task automatic put_bits(input int unsigned v, input int unsigned w);
    for (int unsigned i = 0; i < w; i++) prog_bits.push_back(v[i]);
  endtask

  task automatic put_operand(input logic [1:0] t, input logic [7:0] v);
    put_bits(t, 2);
    put_bits(v, opnd_width(t));
  endtask

  task automatic put_random_instr();
    logic [2:0] op;
    op = 3'($urandom_range(0, 7));
    put_bits(op, 3);
    for (int unsigned k = 0; k < opnd_count(op); k++)
      put_operand(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  task automatic put_random_function(input int unsigned count);
    put_bits(count, 5);
    repeat (count) put_random_instr();
    put_bits($urandom_range(0, 7), 3);
  endtask

  // Idle length: mostly short, a few long, with calm stretches
  function automatic int unsigned pick_idle();
    int unsigned r;
    if ((cycle_count / 300) % 4 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Driver: offer bytes from the queue, predict on each transfer
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_program_byte(in_tdata, in_tlast);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (program_bytes.size() > 0) begin
          in_tdata <= program_bytes[0].data;
          in_tlast <= program_bytes[0].first;
          in_tvalid <= 1'b1;
          void'(program_bytes.pop_front());
          send_gap = pick_idle();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back the block up
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_used = 1'b0;
  always @(posedge clk) begin
    cycle_count++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_used && bytes_sent >= 40) begin
      hold_used = 1'b1;
      hold_left = 300;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_idle();
    end
  end

  // Monitor: compare each record transfer with the oldest expectation
  rec_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record with none expected, kind", out_tuser, 0);
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", out_tuser, want.kind);
        check_field("opcode", out_tdata[2:0], want.opcode);
        check_field("operand_a_type", out_tdata[4:3], want.a_type);
        check_field("operand_a_value", out_tdata[12:5], want.a_value);
        check_field("operand_b_type", out_tdata[14:13], want.b_type);
        check_field("operand_b_value", out_tdata[22:15], want.b_value);
        check_field("label_number", out_tdata[25:23], want.label);
        check_field("padding_bits", out_tdata[29:26], want.pad);
        check_field("spare_bits", out_tdata[31:30], 0);
        check_field("end_of_program", out_tlast, want.eop);
      end
    end
  end

  // Build the file, run it through, then wait for the last records
  initial begin
    int unsigned start;
    int unsigned cut;
    logic [7:0]  b;

    // Zero instruction count, label at its maximum
    put_bits(0, 5);
    put_bits(7, 3);
    // Every opcode once, operand types and values at their extremes
    put_bits(8, 5);
    put_bits(0, 3); put_operand(2'd0, 8'hFF); put_operand(2'd1, 8'd7);
    put_bits(1, 3); put_operand(2'd2, 8'd31);
    put_bits(2, 3);
    put_bits(3, 3); put_operand(2'd3, 8'd0); put_operand(2'd0, 8'd0);
    put_bits(4, 3); put_operand(2'd1, 8'd0); put_operand(2'd2, 8'd0);
    put_bits(5, 3); put_operand(2'd3, 8'd31);
    put_bits(6, 3); put_operand(2'd0, 8'h5A);
    put_bits(7, 3); put_operand(2'd1, 8'd5);
    put_bits(0, 3);
    // Maximum instruction count, all without operands
    put_bits(31, 5);
    repeat (31) put_bits(2, 3);
    put_bits(3, 3);

    // Random functions, mostly short, now and then a full one
    while (prog_bits.size() < 8 * 165)
      put_random_function(($urandom_range(0, 19) == 0) ? 31 : $urandom_range(0, 7));

    // Either a clean end with padding or a file cut inside its last function
    if ($urandom_range(0, 1) == 0) begin
      start = prog_bits.size();
      put_random_function($urandom_range(1, 7));
      cut = start + $urandom_range(1, prog_bits.size() - start - 1);
      while (prog_bits.size() > cut) void'(prog_bits.pop_back());
    end
    while (prog_bits.size() % 8 != 0) prog_bits.push_back(1'($urandom_range(0, 1)));

    total_bytes = prog_bits.size() / 8;
    for (int unsigned i = 0; i < total_bytes; i++) begin
      for (int unsigned j = 0; j < 8; j++) b[j] = prog_bits[8 * i + j];
      program_bytes.push_back('{data: b, first: (i == total_bytes - 1)});
    end

    // Hold reset, then release it
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_sent < total_bytes) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0 && expected_records.size() == 0)
      $display("reverse_bitstream_instruction_decoder test passed");
    else
      $display("reverse_bitstream_instruction_decoder test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("reverse_bitstream_instruction_decoder test failed");
    $finish;
  end

endmodule
